// File: hdl/rtwc_pkg.sv
// Shared types and constants for the ratio-threshold weighted centroid block.
`default_nettype none

package rtwc_pkg;

  // Default frame geometry limits.
  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF    = 1024;

  // Field and register widths.
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned FW_W     = 11;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned CENTRE_W = 10;
  localparam int unsigned CFG_W    = FW_W;
  localparam int unsigned PROD_W   = 18;

  // Reset values of the configuration registers.
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST     = 11'd160;
  localparam logic [THR_W-1:0] RATIO_THRESHOLD_RST = 10'd410;

  // Scale of the ratio threshold (threshold is in units of 1/500).
  localparam logic [PROD_W-1:0] RATIO_SCALE = 18'd500;

  // Largest centroid coordinate that fits the result fields.
  localparam logic [CENTRE_W-1:0] CENTRE_MAX = {CENTRE_W{1'b1}};

  // Quotient steps: one saturation check plus one step per result bit.
  localparam int unsigned DIV_STEPS  = CENTRE_W + 1;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH     = 1'b0,
    CFG_RATIO_THRESHOLD = 1'b1
  } cfg_index_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// File: hdl/ratio_threshold_weighted_centroid.sv
// Ratio-threshold weighted centroid: pixel mask, moment sums and per-frame centroid.
`default_nettype none

// Takes one pixel per request in raster order and returns one result per pixel.
// A pixel is kept when 500*fg_weight > bg_weight*ratio_threshold; kept pixels add
// their weight to exact weight and moment sums. An ordinary pixel passes from
// acceptance to the next through latch, accumulate and load output register;
// the load waits for a free output register. The pixel marked end_of_frame
// also runs two divisions: one shared restoring subtract-and-compare unit
// produces one quotient bit per cycle, first for the x centroid and then for
// the y centroid. in_stall_o is high while an item is in work. A finished
// result sits in the output register until taken; a new pixel may be accepted
// meanwhile. Quotients saturate at 1023; an empty frame sets frame_empty_o and
// gives centre 0. frame_width of 0 acts as 1, and values above MAX_COLUMNS act
// as MAX_COLUMNS; row counting saturates at MAX_ROWS-1.
module ratio_threshold_weighted_centroid #(
  parameter int unsigned MAX_COLUMNS = rtwc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = rtwc_pkg::MAX_ROWS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_we_i,
  input  wire                              cfg_index_i,
  input  wire  [rtwc_pkg::CFG_W-1:0]       cfg_data_i,
  // pixel input
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [rtwc_pkg::WEIGHT_W-1:0]    fg_weight_i,
  input  wire  [rtwc_pkg::WEIGHT_W-1:0]    bg_weight_i,
  input  wire                              end_of_frame_i,
  // result output
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             mask_value_o,
  output logic                             frame_done_o,
  output logic                             frame_empty_o,
  output logic [rtwc_pkg::CENTRE_W-1:0]    centre_x_o,
  output logic [rtwc_pkg::CENTRE_W-1:0]    centre_y_o
);
  import rtwc_pkg::*;

  localparam int unsigned COL_W   = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned TOT_W   = WEIGHT_W + COL_W + ROW_W;
  localparam int unsigned POS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned MOM_W   = TOT_W + POS_W;
  localparam int unsigned DIV_W0  = (MOM_W > TOT_W + CENTRE_W) ? MOM_W : TOT_W + CENTRE_W;
  localparam int unsigned DIV_W   = DIV_W0 + 1;
  localparam int unsigned WID_W   = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;
  localparam int unsigned RCMP_W  = ROW_W + 1;
  localparam int unsigned XPROD_W = COL_W + WEIGHT_W;
  localparam int unsigned YPROD_W = ROW_W + WEIGHT_W;

  // Configuration registers.
  logic [FW_W-1:0]  frame_width_q;
  logic [THR_W-1:0] ratio_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= FRAME_WIDTH_RST;
      ratio_threshold_q <= RATIO_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH:     frame_width_q     <= cfg_data_i;
        CFG_RATIO_THRESHOLD: ratio_threshold_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_e                state_q, state_d;
  logic [WEIGHT_W-1:0]   fg_q, bg_q;
  logic                  last_q;
  logic                  keep_q, keep_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [TOT_W-1:0]      total_q, total_d;
  logic [MOM_W-1:0]      xmom_q, xmom_d;
  logic [MOM_W-1:0]      ymom_q, ymom_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIV_W-1:0]      dvs_q, dvs_d;
  logic [DIV_STEPS-1:0]  quo_q, quo_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic                  sel_y_q, sel_y_d;
  logic [CENTRE_W-1:0]   cx_q, cx_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_mask_q, out_done_q, out_empty_q;
  logic [CENTRE_W-1:0]   out_cx_q, out_cy_q;
  logic                  out_load;

  logic                  in_accept;
  logic                  out_free;
  logic [PROD_W-1:0]     fg_side, bg_side;
  logic                  keep_now;
  logic [XPROD_W-1:0]    x_prod;
  logic [YPROD_W-1:0]    y_prod;
  logic [WID_W-1:0]      fw_ext, eff_width, col_next;
  logic [RCMP_W-1:0]     row_next;
  logic                  div_ge;
  logic [CENTRE_W-1:0]   quo_result;
  logic                  total_zero;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Ratio test and moment products.
  assign fg_side  = RATIO_SCALE * PROD_W'(fg_q);
  assign bg_side  = PROD_W'(bg_q) * PROD_W'(ratio_threshold_q);
  assign keep_now = fg_side > bg_side;
  assign x_prod   = XPROD_W'(col_q) * XPROD_W'(fg_q);
  assign y_prod   = YPROD_W'(row_q) * YPROD_W'(fg_q);

  // Clamp frame width to 1..MAX_COLUMNS.
  assign fw_ext    = WID_W'(frame_width_q);
  assign eff_width = (fw_ext == '0) ? WID_W'(1) :
                     (fw_ext > WID_W'(MAX_COLUMNS)) ? WID_W'(MAX_COLUMNS) : fw_ext;
  assign col_next  = WID_W'(col_q) + WID_W'(1);
  assign row_next  = RCMP_W'(row_q) + RCMP_W'(1);

  // Shared subtract-and-compare unit.
  assign div_ge     = rem_q >= dvs_q;
  assign total_zero = (total_q == '0);
  assign quo_result = total_zero ? '0 :
                      quo_q[DIV_STEPS-1] ? CENTRE_MAX : quo_q[CENTRE_W-1:0];

  always_comb begin
    state_d     = state_q;
    keep_d      = keep_q;
    col_d       = col_q;
    row_d       = row_q;
    total_d     = total_q;
    xmom_d      = xmom_q;
    ymom_d      = ymom_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    step_d      = step_q;
    sel_y_d     = sel_y_q;
    cx_d        = cx_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_CALC;
      end
      ST_CALC: begin
        keep_d = keep_now;
        if (keep_now) begin
          total_d = total_q + TOT_W'(fg_q);
          xmom_d  = xmom_q + MOM_W'(x_prod);
          ymom_d  = ymom_q + MOM_W'(y_prod);
        end
        if (last_q) begin
          sel_y_d = 1'b0;
          state_d = ST_LOAD;
        end else begin
          if (col_next >= eff_width) begin
            col_d = '0;
            if (row_next < RCMP_W'(MAX_ROWS)) row_d = row_next[ROW_W-1:0];
          end else begin
            col_d = col_next[COL_W-1:0];
          end
          state_d = ST_EMIT;
        end
      end
      ST_LOAD: begin
        rem_d   = sel_y_q ? DIV_W'(ymom_q) : DIV_W'(xmom_q);
        dvs_d   = DIV_W'(total_q) << CENTRE_W;
        quo_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // First step flags a quotient too large for the result field.
        if (div_ge) rem_d = rem_q - dvs_q;
        quo_d  = {quo_q[DIV_STEPS-2:0], div_ge};
        dvs_d  = dvs_q >> 1;
        step_d = step_q + DIV_STEP_W'(1);
        if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
          if (sel_y_q) begin
            state_d = ST_EMIT;
          end else begin
            sel_y_d = 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_EMIT: begin
        if (sel_y_q && last_q) begin
          // hold quotient until the output slot frees
        end else if (!sel_y_q && last_q) begin
          cx_d = quo_result;
        end
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (last_q) begin
            col_d   = '0;
            row_d   = '0;
            total_d = '0;
            xmom_d  = '0;
            ymom_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Capture x centroid when its division finishes.
    if (state_q == ST_DIV && !sel_y_q && step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
      cx_d = total_zero ? '0 :
             quo_d[DIV_STEPS-1] ? CENTRE_MAX : quo_d[CENTRE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      total_q     <= '0;
      xmom_q      <= '0;
      ymom_q      <= '0;
      step_q      <= '0;
      sel_y_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      total_q     <= total_d;
      xmom_q      <= xmom_d;
      ymom_q      <= ymom_d;
      step_q      <= step_d;
      sel_y_q     <= sel_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fg_q   <= fg_weight_i;
      bg_q   <= bg_weight_i;
      last_q <= end_of_frame_i;
    end
    keep_q <= keep_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    cx_q   <= cx_d;
    if (out_load) begin
      out_mask_q  <= keep_q;
      out_done_q  <= last_q;
      out_empty_q <= last_q && total_zero;
      out_cx_q    <= last_q ? cx_q : '0;
      out_cy_q    <= last_q ? quo_result : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mask_value_o  = out_mask_q;
  assign frame_done_o  = out_done_q;
  assign frame_empty_o = out_empty_q;
  assign centre_x_o    = out_cx_q;
  assign centre_y_o    = out_cy_q;

  // A result appears only after the sequencer reaches the emit state.
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit state");

  // An accepted pixel is worked on in the very next cycle.
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_CALC)
    else $error("accepted pixel not processed");

  // The division never runs past its step count.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> step_q < DIV_STEP_W'(DIV_STEPS))
    else $error("division step overrun");

  // An empty frame reports a finished frame with a zero centroid.
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_empty_o |-> frame_done_o && centre_x_o == '0 && centre_y_o == '0)
    else $error("empty frame with nonzero centroid");

  // Non-final pixels never carry centroid data.
  a_plain_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> !frame_empty_o && centre_x_o == '0 && centre_y_o == '0)
    else $error("centroid on a non-final pixel");

endmodule

`default_nettype wire

// File: bench/tb_ratio_threshold_weighted_centroid.sv
// Self-checking testbench for the ratio-threshold weighted centroid block.
`timescale 1ns / 1ps

module tb_ratio_threshold_weighted_centroid;

  import rtwc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [WEIGHT_W-1:0] fg;
    logic [WEIGHT_W-1:0] bg;
    logic                eof;
  } pixel_t;

  typedef struct packed {
    logic                mask;
    logic                done;
    logic                empty;
    logic [CENTRE_W-1:0] cx;
    logic [CENTRE_W-1:0] cy;
  } centroid_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic                cfg_index_i    = 1'b0;
  logic [CFG_W-1:0]    cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [WEIGHT_W-1:0] fg_weight_i    = '0;
  logic [WEIGHT_W-1:0] bg_weight_i    = '0;
  logic                end_of_frame_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                mask_value_o;
  logic                frame_done_o;
  logic                frame_empty_o;
  logic [CENTRE_W-1:0] centre_x_o;
  logic [CENTRE_W-1:0] centre_y_o;

  pixel_t      pixel_q[$];
  centroid_t   centroid_q[$];
  int unsigned idle_pct     = 14;
  int unsigned err_count    = 0;
  int unsigned results_seen = 0;
  int unsigned hold_cycles  = 0;
  int unsigned cycle_count  = 0;

  // Shadow copy of the block's registers and frame accumulators.
  logic [FW_W-1:0]  width_reg  = FRAME_WIDTH_RST;
  logic [THR_W-1:0] thresh_reg = RATIO_THRESHOLD_RST;
  logic [9:0]       col_pos    = '0;
  logic [9:0]       row_pos    = '0;
  logic [27:0]      weight_sum = '0;
  logic [37:0]      x_sum      = '0;
  logic [37:0]      y_sum      = '0;

  ratio_threshold_weighted_centroid i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .fg_weight_i   (fg_weight_i),
    .bg_weight_i   (bg_weight_i),
    .end_of_frame_i(end_of_frame_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mask_value_o  (mask_value_o),
    .frame_done_o  (frame_done_o),
    .frame_empty_o (frame_empty_o),
    .centre_x_o    (centre_x_o),
    .centre_y_o    (centre_y_o)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Apply one pixel to the shadow accumulators and return the result it yields.
  function automatic centroid_t mask_and_centroid(pixel_t px);
    centroid_t   r;
    int unsigned width;
    bit          keep;
    logic [37:0] q;
    width = (width_reg == 0) ? 1 :
            (width_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(width_reg);
    keep  = (500 * int'(px.fg)) > (int'(px.bg) * int'(thresh_reg));
    r = '0;
    r.mask = keep;
    if (keep) begin
      weight_sum += 28'(px.fg);
      x_sum      += 38'(col_pos) * 38'(px.fg);
      y_sum      += 38'(row_pos) * 38'(px.fg);
    end
    if (px.eof) begin
      r.done  = 1'b1;
      r.empty = (weight_sum == 0);
      if (weight_sum != 0) begin
        q    = x_sum / 38'(weight_sum);
        r.cx = (q > 38'(CENTRE_MAX)) ? CENTRE_MAX : q[CENTRE_W-1:0];
        q    = y_sum / 38'(weight_sum);
        r.cy = (q > 38'(CENTRE_MAX)) ? CENTRE_MAX : q[CENTRE_W-1:0];
      end
      col_pos    = '0;
      row_pos    = '0;
      weight_sum = '0;
      x_sum      = '0;
      y_sum      = '0;
    end else if (int'(col_pos) + 1 >= width) begin
      col_pos = '0;
      if (int'(row_pos) + 1 < MAX_ROWS_DEF) row_pos++;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  // Called at a falling edge while the block is idle.
  task automatic write_reg(cfg_index_e idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CFG_FRAME_WIDTH) width_reg = data;
    else thresh_reg = data[THR_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_pixel(int unsigned fg, int unsigned bg, bit eof);
    pixel_t px;
    px.fg  = WEIGHT_W'(fg);
    px.bg  = WEIGHT_W'(bg);
    px.eof = eof;
    pixel_q.push_back(px);
  endtask

  // Queue a frame of random pixels; leave it open when close_frame is 0.
  task automatic add_frame(int unsigned len, bit close_frame);
    pixel_t      px;
    int unsigned style;
    int          near_fg;
    style = $urandom_range(0, 3);
    for (int unsigned i = 0; i < len; i++) begin
      px.fg = WEIGHT_W'($urandom);
      px.bg = WEIGHT_W'($urandom);
      case (style)
        1: begin
          // land on either side of the ratio boundary
          near_fg = (int'(px.bg) * int'(thresh_reg)) / 500 + int'($urandom_range(0, 2)) - 1;
          px.fg   = (near_fg < 0) ? '0 : (near_fg > 255) ? 8'd255 : WEIGHT_W'(near_fg);
        end
        2: if ($urandom_range(0, 3) != 0) px.fg = '0;
        3: if ($urandom_range(0, 15) != 0) px.fg = '0;
        default: ;
      endcase
      px.eof = close_frame && (i == len - 1);
      pixel_q.push_back(px);
    end
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || centroid_q.size() != 0) @(negedge clk_i);
  endtask

  // Driver: sample the handshake at the rising edge, advance at the falling edge.
  always @(posedge clk_i) begin : pixel_driver
    bit taken;
    taken = rst_ni && in_valid_i && !in_stall_o;
    @(negedge clk_i);
    if (taken) begin
      centroid_q.push_back(mask_and_centroid(pixel_q[0]));
      void'(pixel_q.pop_front());
    end
    if (in_valid_i && !taken) begin
      // hold the stalled request
    end else if (pixel_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      in_valid_i     <= 1'b1;
      fg_weight_i    <= pixel_q[0].fg;
      bg_weight_i    <= pixel_q[0].bg;
      end_of_frame_i <= pixel_q[0].eof;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor: check each accepted result, then pick the next stall value.
  always @(posedge clk_i) begin : result_monitor
    centroid_t got;
    centroid_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.mask  = mask_value_o;
      got.done  = frame_done_o;
      got.empty = frame_empty_o;
      got.cx    = centre_x_o;
      got.cy    = centre_y_o;
      if (centroid_q.size() == 0) begin
        $error("unexpected result: mask_value %0d frame_done %0d", got.mask, got.done);
        err_count++;
      end else begin
        want = centroid_q.pop_front();
        if (got.mask !== want.mask) begin
          $error("mask_value: expected %0d, got %0d", want.mask, got.mask);
          err_count++;
        end
        if (got.done !== want.done) begin
          $error("frame_done: expected %0d, got %0d", want.done, got.done);
          err_count++;
        end
        if (got.empty !== want.empty) begin
          $error("frame_empty: expected %0d, got %0d", want.empty, got.empty);
          err_count++;
        end
        if (got.cx !== want.cx) begin
          $error("centre_x: expected %0d, got %0d", want.cx, got.cx);
          err_count++;
        end
        if (got.cy !== want.cy) begin
          $error("centre_y: expected %0d, got %0d", want.cy, got.cy);
          err_count++;
        end
      end
      results_seen++;
      // back up the pipeline so the input side stalls
      if (results_seen == 100 || results_seen == 900) hold_cycles = HOLD_CYCLES;
    end
    @(negedge clk_i);
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ratio_threshold_weighted_centroid: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned iter;
    int unsigned len;
    bit          close_frame;
    logic [CFG_W-1:0] wdata;

    rand_items = 0;
    iter       = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset register values: empty frame, then a small frame.
    add_pixel(0, 0, 1'b1);
    add_pixel(255, 255, 1'b0);
    add_pixel(1, 0, 1'b0);
    add_pixel(0, 255, 1'b0);
    add_pixel(200, 255, 1'b0);
    add_pixel(128, 100, 1'b1);
    drain();

    // Narrow rows, top threshold, right at the boundary.
    write_reg(CFG_FRAME_WIDTH, 11'd3);
    write_reg(CFG_RATIO_THRESHOLD, 11'd1023);
    add_pixel(255, 124, 1'b0);
    add_pixel(255, 125, 1'b0);
    add_pixel(255, 0, 1'b0);
    add_pixel(10, 4, 1'b0);
    add_pixel(7, 3, 1'b0);
    add_pixel(0, 0, 1'b0);
    add_pixel(255, 255, 1'b1);
    drain();

    // Equal ratio is not kept; shrink the width in the middle of a row.
    write_reg(CFG_FRAME_WIDTH, 11'd5);
    write_reg(CFG_RATIO_THRESHOLD, 11'd500);
    add_pixel(100, 100, 1'b0);
    add_pixel(101, 100, 1'b0);
    add_pixel(50, 0, 1'b0);
    add_pixel(255, 1, 1'b0);
    drain();
    write_reg(CFG_FRAME_WIDTH, 11'd2);
    add_pixel(200, 10, 1'b0);
    add_pixel(30, 20, 1'b1);
    drain();

    // Zero width acts as one column; zero threshold keeps any nonzero weight.
    write_reg(CFG_FRAME_WIDTH, 11'd0);
    write_reg(CFG_RATIO_THRESHOLD, 11'd0);
    add_pixel(1, 255, 1'b0);
    add_pixel(0, 0, 1'b0);
    add_pixel(9, 9, 1'b1);
    drain();

    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       wdata = 11'd0;
          1:       wdata = 11'd1;
          2:       wdata = 11'd1023;
          3:       wdata = 11'd1024;
          4:       wdata = 11'd1025;
          5:       wdata = 11'd2047;
          6:       wdata = 11'd160;
          7:       wdata = CFG_W'($urandom);
          default: wdata = CFG_W'($urandom_range(1, 64));
        endcase
        write_reg(CFG_FRAME_WIDTH, wdata);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       wdata = 11'd0;
          1:       wdata = 11'd1023;
          2:       wdata = 11'd500;
          3:       wdata = CFG_W'($urandom);
          default: wdata = CFG_W'($urandom_range(0, 1023));
        endcase
        write_reg(CFG_RATIO_THRESHOLD, wdata);
      end
      idle_pct = (iter >= 3 && iter < 9) ? 0 : 14;
      if (iter == 12) begin
        // one column per row: drive the row counter into saturation
        write_reg(CFG_FRAME_WIDTH, 11'd1);
        len         = 1030;
        close_frame = 1'b1;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 48);
        close_frame = ($urandom_range(0, 5) != 0);
      end
      add_frame(len, close_frame);
      rand_items += len;
      drain();
      iter++;
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_count == 0 && centroid_q.size() == 0) begin
      $display("** ratio_threshold_weighted_centroid: PASSED **");
    end else begin
      $display("** ratio_threshold_weighted_centroid: FAILED **");
    end
    $finish;
  end

endmodule

// File: ratio_threshold_weighted_centroid.f
hdl/rtwc_pkg.sv
hdl/ratio_threshold_weighted_centroid.sv
bench/tb_ratio_threshold_weighted_centroid.sv
